/* hdl/abc_to_dq_park_transform_core_assert.svh */
// assertion macros for the abc to dq park transform core
// expects clk and rst_n in the scope of the including module
`ifndef ABC_TO_DQ_PARK_TRANSFORM_CORE_ASSERT_SVH
`define ABC_TO_DQ_PARK_TRANSFORM_CORE_ASSERT_SVH

// same-cycle implication
`define APT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define APT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/apt_pkg.sv */
// shared types, constants and sine table builder for the park transform core
// no dependencies
`default_nettype none

package apt_pkg;

    localparam int FRAC_BITS       = 24;
    localparam int SINE_TABLE_BITS = 10;
    localparam int ANGLE_W         = 24;
    localparam int PHASE_W         = 32;
    localparam int AXIS_W          = 32;
    localparam int NUM_PHASES      = 3;
    localparam int NUM_AXES        = 2;
    localparam int NUM_STAGES      = 6;

    localparam int INTERP_W = ANGLE_W - SINE_TABLE_BITS;
    localparam int QUARTER  = 2 ** (SINE_TABLE_BITS - 2);
    localparam int QIDX_W   = SINE_TABLE_BITS - 1;
    localparam int SINE_W   = FRAC_BITS + 2;
    localparam int TERM_W   = PHASE_W + 2;
    localparam int SUM_W    = TERM_W + 2;
    localparam int SCALED_W = SUM_W + 1;

    localparam longint unsigned TWO_PI_Q30   = 64'd6746518852;
    localparam longint          ONE_Q30      = 64'sd1073741824;
    localparam longint          SQRT_2_3_Q30 = 64'sd876706528;

    typedef logic        [ANGLE_W-1:0]         angle_t;
    typedef logic signed [PHASE_W-1:0]         phase_t;
    typedef logic signed [AXIS_W-1:0]          axis_t;
    typedef logic signed [SINE_W-1:0]          sine_t;
    typedef logic        [FRAC_BITS:0]         mag_t;
    typedef logic signed [TERM_W-1:0]          term_t;
    typedef logic signed [SUM_W-1:0]           sum_t;
    typedef logic signed [SCALED_W-1:0]        scaled_t;
    typedef logic        [SINE_TABLE_BITS-1:0] tab_idx_t;
    typedef logic        [QIDX_W-1:0]          qidx_t;
    typedef logic        [INTERP_W-1:0]        frac_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctrl_t;

    localparam angle_t ANGLE_ZERO   = angle_t'(0);
    localparam angle_t THIRD_TURN   = angle_t'(5592405);
    localparam angle_t MINUS_THIRD  = angle_t'(2 ** ANGLE_W - 5592405);
    localparam angle_t QUARTER_TURN = angle_t'(2 ** (ANGLE_W - 2));

    localparam angle_t PHASE_OFFSET [NUM_PHASES] = '{ANGLE_ZERO, MINUS_THIRD, THIRD_TURN};

    // round half up of a nonnegative q30 magnitude to the working format
    function automatic longint q30_to_frac(input longint mag);
        if (FRAC_BITS == 30)
        begin
            return mag;
        end
        return (mag + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    endfunction

    // first quadrant sine magnitude, taylor series through x^19 in q30
    function automatic mag_t quarter_sine(input int r);
        longint unsigned x;
        longint unsigned t;
        longint          acc;
        x   = (longint'(r) * TWO_PI_Q30) >> SINE_TABLE_BITS;
        t   = x;
        acc = longint'(x);
        for (int n = 1; n <= 9; n++)
        begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            case (n)
                1:       t = t / 64'd6;
                2:       t = t / 64'd20;
                3:       t = t / 64'd42;
                4:       t = t / 64'd72;
                5:       t = t / 64'd110;
                6:       t = t / 64'd156;
                7:       t = t / 64'd210;
                8:       t = t / 64'd272;
                default: t = t / 64'd342;
            endcase
            if (n % 2 == 1)
            begin
                acc = acc - longint'(t);
            end
            else
            begin
                acc = acc + longint'(t);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        if (acc > ONE_Q30)
        begin
            acc = ONE_Q30;
        end
        return mag_t'(q30_to_frac(acc));
    endfunction

    localparam mag_t K_SCALE = mag_t'(q30_to_frac(SQRT_2_3_Q30));

endpackage

`default_nettype wire

/* hdl/apt_if.sv */
// valid/ready channel interfaces for phase samples in and d/q results out
// depends on apt_pkg
`default_nettype none

interface apt_in_if import apt_pkg::*; ();
    logic   valid;
    logic   ready;
    phase_t phase_a;
    phase_t phase_b;
    phase_t phase_c;
    angle_t angle;

    modport source (output valid, output phase_a, output phase_b, output phase_c,
                    output angle, input ready);
    modport sink   (input valid, input phase_a, input phase_b, input phase_c,
                    input angle, output ready);
endinterface

interface apt_out_if import apt_pkg::*; ();
    logic  valid;
    logic  ready;
    axis_t d_axis;
    axis_t q_axis;

    modport source (output valid, output d_axis, output q_axis, input ready);
    modport sink   (input valid, input d_axis, input q_axis, output ready);
endinterface

`default_nettype wire

/* hdl/apt_lane.sv */
// one lane: rotated angle, interpolated sine lookup, phase product
// depends on apt_pkg; occupies pipeline stages 0 to 2
`default_nettype none

module apt_lane import apt_pkg::*;
(
    input  logic       clk,
    input  pipe_ctrl_t ctrl,
    input  phase_t     phase,
    input  angle_t     angle,
    input  angle_t     offset,
    output term_t      term
);

    // quarter-wave table, one extra entry for the full-scale peak
    mag_t qtab [QUARTER+1];

    for (genvar g = 0; g <= QUARTER; g++)
    begin : g_tab
        assign qtab[g] = quarter_sine(g);
    end

    angle_t   rot;
    tab_idx_t idx   [2];
    qidx_t    qsel  [2];
    sine_t    entry [2];

    sine_t  lo_reg;
    sine_t  hi_reg;
    frac_t  frac_reg;
    phase_t phase0_reg;

    logic signed [SINE_W:0]               diff;
    logic signed [SINE_W+INTERP_W+1:0]    slope;
    logic signed [SINE_W+INTERP_W+1:0]    step;
    sine_t                                sine_next;
    sine_t                                sine_reg;
    phase_t                               phase1_reg;

    logic signed [PHASE_W+SINE_W-1:0]     prod;
    term_t                                term_next;
    term_t                                term_reg;

    // stage 0: table lookups for the entry and its neighbor
    always_comb
    begin
        rot    = angle + offset;
        idx[0] = rot[ANGLE_W-1 -: SINE_TABLE_BITS];
        idx[1] = idx[0] + tab_idx_t'(1);
        for (int k = 0; k < 2; k++)
        begin
            // odd quadrants run the quarter table backwards
            if (idx[k][SINE_TABLE_BITS-2])
            begin
                qsel[k] = qidx_t'(QUARTER) - qidx_t'(idx[k][SINE_TABLE_BITS-3:0]);
            end
            else
            begin
                qsel[k] = qidx_t'(idx[k][SINE_TABLE_BITS-3:0]);
            end
            if (idx[k][SINE_TABLE_BITS-1])
            begin
                entry[k] = -$signed({1'b0, qtab[qsel[k]]});
            end
            else
            begin
                entry[k] = $signed({1'b0, qtab[qsel[k]]});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            lo_reg     <= entry[0];
            hi_reg     <= entry[1];
            frac_reg   <= rot[INTERP_W-1:0];
            phase0_reg <= phase;
        end
    end

    // stage 1: linear interpolation, floor of the scaled step
    always_comb
    begin
        diff      = $signed({hi_reg[SINE_W-1], hi_reg}) - $signed({lo_reg[SINE_W-1], lo_reg});
        slope     = diff * $signed({1'b0, frac_reg});
        step      = slope >>> INTERP_W;
        sine_next = lo_reg + sine_t'(step);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[1])
        begin
            sine_reg   <= sine_next;
            phase1_reg <= phase0_reg;
        end
    end

    // stage 2: phase times sine, truncated toward minus infinity
    always_comb
    begin
        prod      = phase1_reg * sine_reg;
        term_next = term_t'(prod >>> FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[2])
        begin
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

endmodule

`default_nettype wire

/* hdl/apt_merge.sv */
// merging stage: sums the lane terms, scales by sqrt(2/3), saturates
// depends on apt_pkg; occupies pipeline stages 3 to 5
`default_nettype none

module apt_merge import apt_pkg::*;
(
    input  logic       clk,
    input  pipe_ctrl_t ctrl,
    input  term_t      d_term [NUM_PHASES],
    input  term_t      q_term [NUM_PHASES],
    output axis_t      d_axis,
    output axis_t      q_axis
);

    sum_t    sum_next    [NUM_AXES];
    sum_t    sum_reg     [NUM_AXES];
    logic signed [SUM_W+FRAC_BITS+1:0] scale_prod [NUM_AXES];
    scaled_t scaled_next [NUM_AXES];
    scaled_t scaled_reg  [NUM_AXES];
    axis_t   sat_next    [NUM_AXES];
    axis_t   axis_reg    [NUM_AXES];

    function automatic axis_t saturate(input scaled_t v);
        logic [SCALED_W-AXIS_W:0] top;
        top = v[SCALED_W-1:AXIS_W-1];
        if ((&top) || !(|top))
        begin
            return axis_t'(v);
        end
        else if (v[SCALED_W-1])
        begin
            return {1'b1, {(AXIS_W-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(AXIS_W-1){1'b1}}};
        end
    endfunction

    // stage 3: wide sum, no wrap
    always_comb
    begin
        sum_next[0] = '0;
        sum_next[1] = '0;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            sum_next[0] = sum_next[0] + sum_t'(d_term[p]);
            sum_next[1] = sum_next[1] + sum_t'(q_term[p]);
        end
    end

    // stage 4: scale by k, truncate; stage 5: saturate to the axis width
    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            scale_prod[k]  = sum_reg[k] * $signed({1'b0, K_SCALE});
            scaled_next[k] = scaled_t'(scale_prod[k] >>> FRAC_BITS);
            sat_next[k]    = saturate(scaled_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            if (ctrl.load[3])
            begin
                sum_reg[k] <= sum_next[k];
            end
            if (ctrl.load[4])
            begin
                scaled_reg[k] <= scaled_next[k];
            end
            if (ctrl.load[5])
            begin
                axis_reg[k] <= sat_next[k];
            end
        end
    end

    assign d_axis = axis_reg[0];
    assign q_axis = axis_reg[1];

endmodule

`default_nettype wire

/* hdl/abc_to_dq_park_transform_core.sv */
// top level of the power-invariant abc to dq park transform
// depends on apt_pkg, apt_if, apt_lane, apt_merge and the assertion macro header
`default_nettype none

// Takes one beat of phase samples a, b, c and a rotor angle per clock, at a
// sustained rate of one beat per clock while dq_out is ready. The six
// register stages are: interpolated sine table lookup, the interpolation
// multiply, the phase multiply, the three-phase sum, the sqrt(2/3) scaling
// multiply and saturation. d and q are carried through these registers in
// order and leave from the saturation register. Six lanes (cos and sin for
// each phase) run side by side and a merging stage combines them. Every
// stage holds its beat under backpressure and empty stages keep filling.
// While a finished result waits at the output, the input stays ready until
// all six stages hold beats; after that, input ready follows dq_out.ready in
// the same cycle. There is no memory to initialize; the block takes beats
// from the first cycle after reset.

module abc_to_dq_park_transform_core import apt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    apt_in_if.sink     abc_in,
    apt_out_if.source  dq_out
);

`include "abc_to_dq_park_transform_core_assert.svh"

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] load;
    pipe_ctrl_t            ctrl;

    phase_t phases [NUM_PHASES];
    term_t  d_term [NUM_PHASES];
    term_t  q_term [NUM_PHASES];

    // a stage loads when empty or when the next one loads; last on dq_out.ready
    always_comb
    begin
        load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || dq_out.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
        valid_next[0] = load[0] ? abc_in.valid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            valid_next[k] = load[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.load    = load;
    assign abc_in.ready = load[0];
    assign dq_out.valid = valid_reg[NUM_STAGES-1];

    assign phases[0] = abc_in.phase_a;
    assign phases[1] = abc_in.phase_b;
    assign phases[2] = abc_in.phase_c;

    for (genvar p = 0; p < NUM_PHASES; p++)
    begin : g_phase
        localparam angle_t COS_OFFSET = PHASE_OFFSET[p] + QUARTER_TURN;

        apt_lane u_cos_lane
        (
            .clk    (clk),
            .ctrl   (ctrl),
            .phase  (phases[p]),
            .angle  (abc_in.angle),
            .offset (COS_OFFSET),
            .term   (d_term[p])
        );

        apt_lane u_sin_lane
        (
            .clk    (clk),
            .ctrl   (ctrl),
            .phase  (phases[p]),
            .angle  (abc_in.angle),
            .offset (PHASE_OFFSET[p]),
            .term   (q_term[p])
        );
    end

    apt_merge u_merge
    (
        .clk    (clk),
        .ctrl   (ctrl),
        .d_term (d_term),
        .q_term (q_term),
        .d_axis (dq_out.d_axis),
        .q_axis (dq_out.q_axis)
    );

    `APT_ASSERT_NEXT(a_accept_lands, abc_in.valid && abc_in.ready, valid_reg[0], "accepted beat lost at stage 0")
    `APT_ASSERT_NOW(a_empty_out_ready, !valid_reg[NUM_STAGES-1], abc_in.ready, "input stalled with empty output register")
    `APT_ASSERT_NEXT(a_blocked_holds, valid_reg[2] && !load[3], valid_reg[2], "blocked lane beat dropped")
    `APT_ASSERT_NOW(a_out_source, $rose(dq_out.valid), $past(valid_reg[NUM_STAGES-2]), "result without a beat behind it")

endmodule

`default_nettype wire
